>>> src/assert_macros.svh
// Assertion macros shared by the frame handler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSFH_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("lsfh assertion failed");
`define LSFH_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);
`else
`define LSFH_ASSERT(label, prop)
`define LSFH_ASSERT_MSG(label, prop, msg)
`endif
`endif

>>> src/lsfh_pkg.sv
// Types, codes and helper functions of the LIN slave frame handler.
`default_nettype none
package lsfh_pkg;

    localparam logic [3:0] MAX_DATA_BYTES = 4'd8;
    localparam int         CFG_INDEX_W    = 3;
    localparam int         ENTRY_W        = 13;

    typedef enum logic [1:0] {
        CMD_HEADER      = 2'd0,
        CMD_RX_DATA     = 2'd1,
        CMD_RX_CHECKSUM = 2'd2,
        CMD_TX_DATA     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_IGNORED  = 3'd0,
        KIND_RX_ARMED = 3'd1,
        KIND_TX_REQ   = 3'd2,
        KIND_TX_BYTE  = 3'd3,
        KIND_RX_OK    = 3'd4,
        KIND_CK_ERR   = 3'd5,
        KIND_SEQ_ERR  = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        FS_IDLE = 2'd0,
        FS_RX   = 2'd1,
        FS_TX   = 2'd2
    } frame_state_t;

    typedef struct packed {
        logic       enabled;
        logic [3:0] length;
        logic       enhanced;
        logic       transmit;
        logic [5:0] id;
    } frame_entry_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [2:0] slot;
        logic [3:0] count;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } engine_out_t;

    // Identifier with its two LIN parity bits on top.
    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // Eight-bit sum where the carry out is added back in.
    function automatic logic [7:0] add_end_around(input logic [7:0] s, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, s} + {1'b0, b};
        return t[7:0] + {7'd0, t[8]};
    endfunction

endpackage
`default_nettype wire

>>> src/lsfh_engine.sv
// Frame matching, checksum state and result generation for one accepted word.
`default_nettype none
module lsfh_engine #(
    parameter int FRAME_SLOTS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic [1:0]            cmd,
    input  wire logic [7:0]            byte_value,
    input  wire lsfh_pkg::frame_entry_t entries [FRAME_SLOTS],
    output lsfh_pkg::engine_out_t      eng_out
);

    lsfh_pkg::frame_state_t state_reg, state_next;
    logic [2:0] slot_reg, slot_next;
    logic       enhanced_reg, enhanced_next;
    logic [7:0] pid_reg, pid_next;
    logic [3:0] exp_len_reg, exp_len_next;
    logic [3:0] seen_reg, seen_next;
    logic [7:0] sum_reg, sum_next;

    logic                   hit;
    logic [2:0]             hit_slot;
    lsfh_pkg::frame_entry_t hit_entry;
    logic [7:0]             pid;
    logic [3:0]             len_sat;
    logic [7:0]             seed;
    logic [7:0]             sum_add;
    logic [3:0]             seen_inc;
    lsfh_pkg::result_t      seq_res;
    lsfh_pkg::cmd_t         cmd_v;

    // The highest-numbered enabled entry with a matching identifier wins.
    always_comb begin
        hit       = 1'b0;
        hit_slot  = '0;
        hit_entry = '0;
        for (int i = 0; i < FRAME_SLOTS; i++) begin
            if (entries[i].enabled && entries[i].id == byte_value[5:0]) begin
                hit       = 1'b1;
                hit_slot  = 3'(i);
                hit_entry = entries[i];
            end
        end
    end

    assign pid      = lsfh_pkg::protect_id(byte_value[5:0]);
    assign len_sat  = (hit_entry.length > lsfh_pkg::MAX_DATA_BYTES) ?
                      lsfh_pkg::MAX_DATA_BYTES : hit_entry.length;
    assign seed     = hit_entry.enhanced ? pid : 8'd0;
    assign sum_add  = lsfh_pkg::add_end_around(sum_reg, byte_value);
    assign seen_inc = seen_reg + 4'd1;
    assign cmd_v    = lsfh_pkg::cmd_t'(cmd);

    always_comb begin
        seq_res = '{kind: lsfh_pkg::KIND_SEQ_ERR, out_byte: pid_reg, slot: slot_reg,
                    count: seen_reg, last: 1'b1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lsfh_pkg::FS_IDLE;
            slot_reg     <= '0;
            enhanced_reg <= 1'b0;
            pid_reg      <= '0;
            exp_len_reg  <= '0;
            seen_reg     <= '0;
            sum_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            enhanced_reg <= enhanced_next;
            pid_reg      <= pid_next;
            exp_len_reg  <= exp_len_next;
            seen_reg     <= seen_next;
            sum_reg      <= sum_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        enhanced_next = enhanced_reg;
        pid_next      = pid_reg;
        exp_len_next  = exp_len_reg;
        seen_next     = seen_reg;
        sum_next      = sum_reg;
        eng_out       = '0;

        if (accept) begin
            unique case (cmd_v) inside
                lsfh_pkg::CMD_HEADER: begin
                    // A header always closes whatever frame was open.
                    state_next    = lsfh_pkg::FS_IDLE;
                    eng_out.count = 2'd1;
                    if (hit) begin
                        slot_next     = hit_slot;
                        enhanced_next = hit_entry.enhanced;
                        pid_next      = pid;
                        exp_len_next  = len_sat;
                        seen_next     = '0;
                        sum_next      = seed;
                        eng_out.first = '{kind: hit_entry.transmit ? lsfh_pkg::KIND_TX_REQ :
                                                 lsfh_pkg::KIND_RX_ARMED,
                                          out_byte: pid, slot: hit_slot,
                                          count: len_sat, last: 1'b0};
                        if (!hit_entry.transmit) begin
                            state_next = lsfh_pkg::FS_RX;
                        end else if (len_sat == 4'd0) begin
                            // An empty transmit frame sends its checksum at once.
                            eng_out.count  = 2'd2;
                            eng_out.second = '{kind: lsfh_pkg::KIND_TX_BYTE, out_byte: ~seed,
                                               slot: hit_slot, count: 4'd0, last: 1'b1};
                        end else begin
                            state_next = lsfh_pkg::FS_TX;
                        end
                    end
                end
                lsfh_pkg::CMD_RX_DATA, lsfh_pkg::CMD_RX_CHECKSUM: begin
                    if (state_reg == lsfh_pkg::FS_IDLE) begin
                        eng_out.count = 2'd1;
                    end else if (state_reg != lsfh_pkg::FS_RX ||
                                 (cmd_v == lsfh_pkg::CMD_RX_DATA &&
                                  seen_reg >= lsfh_pkg::MAX_DATA_BYTES)) begin
                        eng_out.count = 2'd1;
                        eng_out.first = seq_res;
                        state_next    = lsfh_pkg::FS_IDLE;
                    end else if (cmd_v == lsfh_pkg::CMD_RX_DATA) begin
                        sum_next  = sum_add;
                        seen_next = seen_inc;
                    end else begin
                        eng_out.count = 2'd1;
                        eng_out.first = '{kind: (~sum_reg == byte_value) ?
                                                lsfh_pkg::KIND_RX_OK : lsfh_pkg::KIND_CK_ERR,
                                          out_byte: pid_reg, slot: slot_reg,
                                          count: seen_reg, last: 1'b1};
                        state_next    = lsfh_pkg::FS_IDLE;
                    end
                end
                lsfh_pkg::CMD_TX_DATA: begin
                    eng_out.count = 2'd1;
                    if (state_reg != lsfh_pkg::FS_TX || seen_reg >= exp_len_reg) begin
                        eng_out.first = seq_res;
                        state_next    = lsfh_pkg::FS_IDLE;
                    end else begin
                        sum_next      = sum_add;
                        seen_next     = seen_inc;
                        eng_out.first = '{kind: lsfh_pkg::KIND_TX_BYTE, out_byte: byte_value,
                                          slot: slot_reg, count: seen_inc, last: 1'b0};
                        if (seen_inc >= exp_len_reg) begin
                            eng_out.count  = 2'd2;
                            eng_out.second = '{kind: lsfh_pkg::KIND_TX_BYTE, out_byte: ~sum_add,
                                               slot: slot_reg, count: seen_inc, last: 1'b1};
                            state_next     = lsfh_pkg::FS_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/lin_slave_frame_handler_core.sv
// A result word is registered in the result queue and is offered on m_ once it reaches the head.
// Throughput: one input word per cycle while s_ready is high; a word yields zero, one or two result words.
// A three-entry result queue decouples the sides; s_ready drops when it holds two or more.
// A frame ending in a second result (tx checksum) puts an extra result word in the queue.
// Reset (aresetn low, synchronous) clears frame entries, frame state and the queue.
`default_nettype none
`include "assert_macros.svh"
module lin_slave_frame_handler_core #(
    parameter int FRAME_SLOTS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [7:0]  s_byte_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_result_kind,
    output logic [7:0]       m_out_byte,
    output logic [2:0]       m_frame_slot,
    output logic [3:0]       m_byte_count,
    output logic             m_last_of_frame
);

    localparam int QUEUE_DEPTH = 3;

    lsfh_pkg::frame_entry_t entry_reg [FRAME_SLOTS];
    lsfh_pkg::engine_out_t  eng;
    lsfh_pkg::result_t      q_reg [QUEUE_DEPTH];
    lsfh_pkg::result_t      q_next [QUEUE_DEPTH];
    lsfh_pkg::result_t      shifted [QUEUE_DEPTH];
    logic [1:0]             cnt_reg, cnt_next;
    logic [1:0]             base;
    logic [1:0]             push_cnt;
    logic                   accept;
    logic                   pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FRAME_SLOTS; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            for (int i = 0; i < FRAME_SLOTS; i++) begin
                if (cfg_index == lsfh_pkg::CFG_INDEX_W'(i)) begin
                    entry_reg[i] <= lsfh_pkg::frame_entry_t'(cfg_wdata);
                end
            end
        end
    end

    assign s_ready = (cnt_reg <= 2'd1);
    assign accept  = s_valid && s_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign pop     = m_valid && m_ready;

    lsfh_engine #(
        .FRAME_SLOTS(FRAME_SLOTS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .cmd        (s_cmd),
        .byte_value (s_byte_value),
        .entries    (entry_reg),
        .eng_out    (eng)
    );

    assign push_cnt = accept ? eng.count : 2'd0;
    assign base     = cnt_reg - {1'b0, pop};
    assign cnt_next = base + push_cnt;

    // Queue advances by one on a pop; new words land right behind the survivors.
    always_comb begin
        shifted[0] = pop ? q_reg[1] : q_reg[0];
        shifted[1] = pop ? q_reg[2] : q_reg[1];
        shifted[2] = q_reg[2];
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_next[i] = shifted[i];
            if (push_cnt != 2'd0 && 2'(i) == base) begin
                q_next[i] = eng.first;
            end else if (push_cnt == 2'd2 && 2'(i) == base + 2'd1) begin
                q_next[i] = eng.second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    assign m_result_kind   = q_reg[0].kind;
    assign m_out_byte      = q_reg[0].out_byte;
    assign m_frame_slot    = q_reg[0].slot;
    assign m_byte_count    = q_reg[0].count;
    assign m_last_of_frame = q_reg[0].last;

    `LSFH_ASSERT(a_second_is_checksum,
        (accept && eng.count == 2'd2) |->
        (eng.second.last && eng.second.kind == lsfh_pkg::KIND_TX_BYTE))
    `LSFH_ASSERT(a_last_kind,
        (m_valid && m_last_of_frame) |->
        (m_result_kind == lsfh_pkg::KIND_TX_BYTE || m_result_kind == lsfh_pkg::KIND_RX_OK ||
         m_result_kind == lsfh_pkg::KIND_CK_ERR || m_result_kind == lsfh_pkg::KIND_SEQ_ERR))
    `LSFH_ASSERT_MSG(a_ignored_clean,
        (m_valid && m_result_kind == lsfh_pkg::KIND_IGNORED) |->
        (m_out_byte == 8'd0 && m_frame_slot == 3'd0 && m_byte_count == 4'd0),
        "ignored result word carries nonzero fields")
    `LSFH_ASSERT_MSG(a_no_overflow,
        (cnt_reg == 2'd3 && !pop) |=> (cnt_reg == 2'd3),
        "result queue lost or invented a word while full")

endmodule
`default_nettype wire
